// File: src/csm_pkg.sv
// csm_pkg: shared types and constants of the criteria set membership block
// used by the controller, the datapath and the top level; no dependencies
package csm_pkg;

	localparam int ELEM_W       = 64;
	localparam int MAX_CRITERIA = 6;
	localparam int SLOT_W       = 3;
	localparam int CNT_W        = 3;
	localparam int BIT_CNT_W    = 6;
	localparam int IDX_W        = 3;
	localparam int OUT_W        = 8;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CRIT_A = 3'd2;

	typedef enum logic [1:0] {
		MODE_EQUAL   = 2'd0,
		MODE_NOT_DIV = 2'd1,
		MODE_DIV     = 2'd2,
		MODE_ALWAYS  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EQ,
		ST_PREP,
		ST_DIV,
		ST_REM,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic                load;
		logic                eq_check;
		logic                zero_mark;
		logic                div_init;
		logic                div_step;
		logic                rem_check;
		logic                out_load;
		logic [SLOT_W-1:0]   slot;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		mode_t               mode;
		logic [CNT_W-1:0]    count;
		logic                crit_zero;
		logic                out_free;
	} stat_t;

endpackage

// File: src/csm_ctrl.sv
// csm_ctrl: sequencer that walks the active criteria and runs the divider
// depends on csm_pkg
module csm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  csm_pkg::stat_t stat,
	output csm_pkg::cmd_t  cmd
);

	csm_pkg::state_t                   state_q, state_d;
	logic [csm_pkg::SLOT_W-1:0]        slot_q, slot_d;
	logic [csm_pkg::BIT_CNT_W-1:0]     bit_q, bit_d;
	logic                              last_slot;

	assign last_slot = ({1'b0, slot_q} + 4'd1) >= {1'b0, stat.count};

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csm_pkg::ST_IDLE;
			slot_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			bit_q   <= bit_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		bit_d    = bit_q;
		cmd      = '0;
		cmd.slot = slot_q;
		s_tready = 1'b0;
		case (state_q)
			csm_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					slot_d   = '0;
					if (stat.mode == csm_pkg::MODE_ALWAYS || stat.count == '0)
						state_d = csm_pkg::ST_DONE;
					else if (stat.mode == csm_pkg::MODE_EQUAL)
						state_d = csm_pkg::ST_EQ;
					else
						state_d = csm_pkg::ST_PREP;
				end
			end
			csm_pkg::ST_EQ: begin
				cmd.eq_check = 1'b1;
				if (last_slot)
					state_d = csm_pkg::ST_DONE;
				else
					slot_d = slot_q + 1'b1;
			end
			csm_pkg::ST_PREP: begin
				if (stat.crit_zero) begin
					cmd.zero_mark = 1'b1;
					if (last_slot)
						state_d = csm_pkg::ST_DONE;
					else
						slot_d = slot_q + 1'b1;
				end else begin
					cmd.div_init = 1'b1;
					bit_d        = '0;
					state_d      = csm_pkg::ST_DIV;
				end
			end
			csm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				bit_d        = bit_q + 1'b1;
				if (bit_q == '1)
					state_d = csm_pkg::ST_REM;
			end
			csm_pkg::ST_REM: begin
				cmd.rem_check = 1'b1;
				if (last_slot) begin
					state_d = csm_pkg::ST_DONE;
				end else begin
					slot_d  = slot_q + 1'b1;
					state_d = csm_pkg::ST_PREP;
				end
			end
			csm_pkg::ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = csm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/csm_dp.sv
// csm_dp: configuration registers, element register, radix-2 remainder unit
// and output register; depends on csm_pkg
module csm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [csm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [csm_pkg::ELEM_W-1:0]   cfg_data,
	input  logic [csm_pkg::ELEM_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csm_pkg::OUT_W-1:0]    m_tdata,
	input  csm_pkg::cmd_t                cmd,
	output csm_pkg::stat_t               stat
);

	csm_pkg::mode_t                  mode_q;
	logic [csm_pkg::CNT_W-1:0]       count_q;
	logic [csm_pkg::ELEM_W-1:0]      crit_q [csm_pkg::MAX_CRITERIA];
	logic [csm_pkg::ELEM_W-1:0]      elem_q;
	logic [csm_pkg::ELEM_W-1:0]      emag_q;
	logic [csm_pkg::ELEM_W-1:0]      dvd_q;
	logic [csm_pkg::ELEM_W-1:0]      rem_q;
	logic [csm_pkg::ELEM_W-1:0]      dsr_q;
	logic                            hit_q, divided_q, zero_q;
	logic                            valid_q, member_q, zflag_q;
	logic [csm_pkg::ELEM_W-1:0]      crit_sel, crit_mag;
	logic [csm_pkg::ELEM_W:0]        trial, trial_sub;
	logic [csm_pkg::IDX_W-1:0]       slot_w;
	logic                            member_d;

	// configuration registers
	assign slot_w = cfg_index - csm_pkg::REG_CRIT_A;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= csm_pkg::MODE_EQUAL;
			count_q <= csm_pkg::CNT_W'(1);
			for (int i = 0; i < csm_pkg::MAX_CRITERIA; i++)
				crit_q[i] <= csm_pkg::ELEM_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == csm_pkg::REG_MODE)
				mode_q <= csm_pkg::mode_t'(cfg_data[1:0]);
			else if (cfg_index == csm_pkg::REG_COUNT)
				count_q <= cfg_data[csm_pkg::CNT_W-1:0];
			else
				crit_q[slot_w] <= cfg_data;
		end
	end

	// criterion select and magnitude
	assign crit_sel = crit_q[cmd.slot];
	assign crit_mag = crit_sel[csm_pkg::ELEM_W-1] ? (~crit_sel + 1'b1) : crit_sel;

	// status to controller, count saturates at the number of slots
	always_comb begin
		stat.mode      = mode_q;
		stat.count     = (count_q > csm_pkg::CNT_W'(csm_pkg::MAX_CRITERIA)) ?
			csm_pkg::CNT_W'(csm_pkg::MAX_CRITERIA) : count_q;
		stat.crit_zero = (crit_sel == '0);
		stat.out_free  = !valid_q || m_tready;
	end

	// restoring remainder step
	assign trial     = {rem_q, dvd_q[csm_pkg::ELEM_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};

	// element, divider and flag registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elem_q    <= s_tdata;
			emag_q    <= s_tdata[csm_pkg::ELEM_W-1] ? (~s_tdata + 1'b1) : s_tdata;
			hit_q     <= 1'b0;
			divided_q <= 1'b0;
			zero_q    <= 1'b0;
		end
		if (cmd.eq_check && crit_sel == elem_q)
			hit_q <= 1'b1;
		if (cmd.zero_mark)
			zero_q <= 1'b1;
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= emag_q;
			dsr_q <= crit_mag;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[csm_pkg::ELEM_W-2:0], 1'b0};
			if (!trial_sub[csm_pkg::ELEM_W])
				rem_q <= trial_sub[csm_pkg::ELEM_W-1:0];
			else
				rem_q <= trial[csm_pkg::ELEM_W-1:0];
		end
		if (cmd.rem_check && rem_q == '0)
			divided_q <= 1'b1;
	end

	// membership by mode
	always_comb begin
		case (mode_q)
			csm_pkg::MODE_EQUAL:   member_d = hit_q;
			csm_pkg::MODE_NOT_DIV: member_d = !divided_q;
			csm_pkg::MODE_DIV:     member_d = divided_q;
			csm_pkg::MODE_ALWAYS:  member_d = 1'b1;
			default:               member_d = 1'b1;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.out_load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			member_q <= member_d;
			zflag_q  <= zero_q;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(csm_pkg::OUT_W-2){1'b0}}, zflag_q, member_q};

endmodule

// File: src/criteria_set_membership.sv
// criteria_set_membership: one element at a time; with n active criteria, equal mode compares
// each criterion in turn; divisibility modes run each nonzero criterion through select, the
// shared 64-step radix-2 remainder unit and check, and mark each zero one; always-true mode or
// n = 0 walks no criterion; next word taken the cycle after the result registers (later under
// output stall); arst_n clears the sequencer, output valid and configuration (mode equal,
// count 1, all criteria 1); depends on csm_pkg, csm_ctrl, csm_dp
module criteria_set_membership (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [csm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [csm_pkg::ELEM_W-1:0]   cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [csm_pkg::ELEM_W-1:0]   s_tdata,   // [63:0] element
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [csm_pkg::OUT_W-1:0]    m_tdata    // [0] is_member, [1] zero_divisor
);

	csm_pkg::cmd_t  cmd;
	csm_pkg::stat_t stat;

	// sequencer
	csm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	csm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: src/csm_checker.sv
// csm_checker: port-level assertions for criteria_set_membership
// depends on csm_pkg; bound to the top level below
module csm_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [csm_pkg::OUT_W-1:0]    m_tdata
);

	// stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed under stall");

	// pad bits of the result word stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[csm_pkg::OUT_W-1:2] == '0)
		else $error("result pad bits set");

	// one element in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a new result appears as the block turns idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result loaded while still busy");

endmodule

bind criteria_set_membership csm_checker u_csm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
